// ===== rtl/gra_pkg.sv =====
// Package for the grid rectangle allocator: operation and status codes,
// port widths and parameter defaults. No dependencies.
package gra_pkg;

    localparam int GRID_ROWS_DEF = 8;
    localparam int GRID_COLS_DEF = 8;
    localparam int MAX_ITEMS_DEF = 63;
    localparam int TAG_BITS_DEF  = 16;

    localparam int OP_W     = 2;
    localparam int DIM_W    = 4;
    localparam int POS_W    = 3;
    localparam int ID_PW    = 6;
    localparam int TAG_PW   = 16;
    localparam int STATUS_W = 2;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_CHECK  = 2'd1;
    localparam op_t OP_REMOVE = 2'd2;
    localparam op_t OP_CLEAR  = 2'd3;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NO_SPACE = 2'd1;
    localparam status_t ST_NO_ID    = 2'd2;
    localparam status_t ST_EXHAUST  = 2'd3;

endpackage

// ===== rtl/gra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module gra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/grid_rectangle_first_fit_allocator.sv =====
// Insert scans the grid row by row, then stamps the found rectangle row by row;
// remove visits every row; check_at visits the rectangle's rows; clear and rejects
// go straight to the result. One item at a time; each grid row passes a read state
// and an evaluate/write state on the one grid RAM.
// Reset (synchronous, aresetn low) clears row valid bits, presence bits and the
// ID counter at once; no clearing pass. Depends on gra_pkg and gra_ram.
module grid_rectangle_first_fit_allocator
    import gra_pkg::*;
#(
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int TAG_BITS  = TAG_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_operation,
    input  logic [DIM_W-1:0]  s_rect_rows,
    input  logic [DIM_W-1:0]  s_rect_cols,
    input  logic [POS_W-1:0]  s_at_row,
    input  logic [POS_W-1:0]  s_at_col,
    input  logic [ID_PW-1:0]  s_item_id,
    input  logic [TAG_PW-1:0] s_item_tag,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [ID_PW-1:0]  m_assigned_id,
    output logic [POS_W-1:0]  m_place_row,
    output logic [POS_W-1:0]  m_place_col,
    output logic [TAG_PW-1:0] m_returned_tag
);
    localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int CNT_W  = $clog2(GRID_ROWS + 1);
    localparam int ID_W   = $clog2(MAX_ITEMS + 1);
    localparam int WORD_W = GRID_COLS * ID_W;
    localparam logic [7:0] ROWS8 = 8'(GRID_ROWS);
    localparam logic [7:0] COLS8 = 8'(GRID_COLS);
    localparam logic [7:0] MAX8  = 8'(MAX_ITEMS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EV   = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // Columns c .. c+w-1 of one row.
    function automatic logic [GRID_COLS-1:0] win_mask(input logic [COL_W-1:0] c,
                                                      input logic [DIM_W-1:0] w);
        logic [GRID_COLS-1:0] m;
        for (int j = 0; j < GRID_COLS; j++) begin
            m[j] = (j >= int'(c)) && (j < int'(c) + int'(w));
        end
        return m;
    endfunction

    logic [1:0]           state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [DIM_W-1:0]     h_reg, h_next, w_reg, w_next;
    logic [ROW_W-1:0]     row_reg, row_next, last_reg, last_next, top_reg, top_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [TAG_BITS-1:0]  tag_in_reg, tag_in_next;
    logic [GRID_COLS-1:0] mask_reg, mask_next;
    logic                 ok_reg, ok_next, stamp_reg, stamp_next;
    logic [CNT_W-1:0]     runs_reg [GRID_COLS];
    logic [CNT_W-1:0]     runs_next [GRID_COLS];
    logic [ID_W-1:0]      issued_reg, issued_next;
    logic [MAX_ITEMS:0]   present_reg, present_next;
    logic [GRID_ROWS-1:0] row_valid_reg, row_valid_next;
    logic                 rv_reg;

    status_t              res_status_reg, res_status_next;
    logic [ID_PW-1:0]     res_id_reg, res_id_next;
    logic [POS_W-1:0]     res_row_reg, res_row_next, res_col_reg, res_col_next;
    logic [TAG_PW-1:0]    res_tag_reg, res_tag_next;
    logic                 m_valid_reg, m_valid_next;
    status_t              m_status_reg;
    logic [ID_PW-1:0]     m_id_reg;
    logic [POS_W-1:0]     m_row_reg, m_col_reg;
    logic [TAG_PW-1:0]    m_tag_reg;

    // Grid RAM: one word per row, one owner ID per column.
    logic                 grid_we;
    logic [WORD_W-1:0]    grid_wdata, grid_rdata, row_data;
    logic                 tag_we;
    logic [ID_W-1:0]      tag_raddr;
    logic [TAG_BITS-1:0]  tag_rdata;

    // Row evaluation.
    logic [GRID_COLS-1:0] free_col, ok_col, fit_col;
    logic [CNT_W-1:0]     run_new [GRID_COLS];
    logic                 any_fit;
    logic [COL_W-1:0]     fit_c;
    logic [ID_W-1:0]      nid;
    logic                 accept, out_take;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_take = !m_valid_reg || m_ready;
    assign nid      = issued_reg + 1'b1;

    gra_ram #(.WIDTH(WORD_W), .DEPTH(GRID_ROWS)) u_grid_ram (
        .aclk  (aclk),
        .we    (grid_we),
        .waddr (row_reg),
        .wdata (grid_wdata),
        .raddr (row_reg),
        .rdata (grid_rdata)
    );

    assign tag_raddr = (state_reg == S_IDLE) ? ID_W'(s_item_id) : id_reg;

    gra_ram #(.WIDTH(TAG_BITS), .DEPTH(MAX_ITEMS + 1)) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (nid),
        .wdata (tag_in_reg),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    // A row never written since reset or clear reads as all free.
    assign row_data = rv_reg ? grid_rdata : '0;

    always_comb begin
        any_fit = 1'b0;
        fit_c   = '0;
        for (int c = 0; c < GRID_COLS; c++) begin
            free_col[c] = (row_data[c*ID_W +: ID_W] == '0);
            run_new[c]  = free_col[c] ? CNT_W'(runs_reg[c] + 1'b1) : '0;
            ok_col[c]   = (8'(run_new[c]) >= 8'(h_reg));
        end
        for (int c = 0; c < GRID_COLS; c++) begin
            fit_col[c] = (8'(c) + 8'(w_reg) <= COLS8)
                && ((ok_col & win_mask(COL_W'(c), w_reg)) == win_mask(COL_W'(c), w_reg));
        end
        for (int c = GRID_COLS - 1; c >= 0; c--) begin
            if (fit_col[c]) begin
                any_fit = 1'b1;
                fit_c   = COL_W'(c);
            end
        end
    end

    // Write-back word: stamp the window with the new ID, or drop the removed ID.
    always_comb begin
        grid_wdata = row_data;
        for (int c = 0; c < GRID_COLS; c++) begin
            if (op_reg == OP_INSERT) begin
                if (mask_reg[c]) begin
                    grid_wdata[c*ID_W +: ID_W] = nid;
                end
            end else if (row_data[c*ID_W +: ID_W] == id_reg) begin
                grid_wdata[c*ID_W +: ID_W] = '0;
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        h_next          = h_reg;
        w_next          = w_reg;
        row_next        = row_reg;
        last_next       = last_reg;
        top_next        = top_reg;
        col_next        = col_reg;
        id_next         = id_reg;
        tag_in_next     = tag_in_reg;
        mask_next       = mask_reg;
        ok_next         = ok_reg;
        stamp_next      = stamp_reg;
        runs_next       = runs_reg;
        issued_next     = issued_reg;
        present_next    = present_reg;
        row_valid_next  = row_valid_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_row_next    = res_row_reg;
        res_col_next    = res_col_reg;
        res_tag_next    = res_tag_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        grid_we         = 1'b0;
        tag_we          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next         = s_operation;
                    h_next          = s_rect_rows;
                    w_next          = s_rect_cols;
                    id_next         = ID_W'(s_item_id);
                    tag_in_next     = TAG_BITS'(s_item_tag);
                    res_status_next = ST_OK;
                    res_id_next     = '0;
                    res_row_next    = '0;
                    res_col_next    = '0;
                    res_tag_next    = '0;
                    row_next        = '0;
                    state_next      = S_DONE;
                    unique case (s_operation)
                        OP_INSERT: begin
                            if (8'(issued_reg) >= MAX8) begin
                                res_status_next = ST_EXHAUST;
                            end else if (s_rect_rows == '0 || s_rect_cols == '0
                                         || 8'(s_rect_rows) > ROWS8
                                         || 8'(s_rect_cols) > COLS8) begin
                                res_status_next = ST_NO_SPACE;
                            end else begin
                                stamp_next = 1'b0;
                                for (int c = 0; c < GRID_COLS; c++) begin
                                    runs_next[c] = '0;
                                end
                                state_next = S_RD;
                            end
                        end
                        OP_CHECK: begin
                            res_row_next = s_at_row;
                            res_col_next = s_at_col;
                            if (s_rect_rows == '0 || s_rect_cols == '0
                                || 8'(s_at_row) + 8'(s_rect_rows) > ROWS8
                                || 8'(s_at_col) + 8'(s_rect_cols) > COLS8) begin
                                res_status_next = ST_NO_SPACE;
                            end else begin
                                row_next   = ROW_W'(s_at_row);
                                last_next  = ROW_W'(8'(s_at_row) + 8'(s_rect_rows) - 8'd1);
                                mask_next  = win_mask(COL_W'(s_at_col), s_rect_cols);
                                ok_next    = 1'b1;
                                state_next = S_RD;
                            end
                        end
                        OP_REMOVE: begin
                            if (s_item_id == '0 || 8'(s_item_id) > MAX8
                                || !present_reg[ID_W'(s_item_id)]) begin
                                res_status_next = ST_NO_ID;
                            end else begin
                                state_next = S_RD;
                            end
                        end
                        OP_CLEAR: begin
                            issued_next    = '0;
                            present_next   = '0;
                            row_valid_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                state_next = S_EV;
            end
            S_EV: begin
                state_next = S_RD;
                row_next   = row_reg + 1'b1;
                unique case (op_reg)
                    OP_INSERT: begin
                        if (!stamp_reg) begin
                            runs_next = run_new;
                            if (any_fit) begin
                                stamp_next = 1'b1;
                                col_next   = fit_c;
                                mask_next  = win_mask(fit_c, w_reg);
                                last_next  = row_reg;
                                top_next   = ROW_W'(8'(row_reg) + 8'd1 - 8'(h_reg));
                                row_next   = ROW_W'(8'(row_reg) + 8'd1 - 8'(h_reg));
                            end else if (row_reg == LAST_ROW) begin
                                res_status_next = ST_NO_SPACE;
                                state_next      = S_DONE;
                            end
                        end else begin
                            grid_we                 = 1'b1;
                            row_valid_next[row_reg] = 1'b1;
                            if (row_reg == last_reg) begin
                                tag_we            = 1'b1;
                                present_next[nid] = 1'b1;
                                issued_next       = nid;
                                res_id_next       = ID_PW'(nid);
                                res_row_next      = POS_W'(top_reg);
                                res_col_next      = POS_W'(col_reg);
                                state_next        = S_DONE;
                            end
                        end
                    end
                    OP_CHECK: begin
                        ok_next = ok_reg && ((free_col & mask_reg) == mask_reg);
                        if (!ok_next) begin
                            res_status_next = ST_NO_SPACE;
                            state_next      = S_DONE;
                        end else if (row_reg == last_reg) begin
                            state_next = S_DONE;
                        end
                    end
                    OP_REMOVE: begin
                        grid_we                 = 1'b1;
                        row_valid_next[row_reg] = 1'b1;
                        if (row_reg == LAST_ROW) begin
                            present_next[id_reg] = 1'b0;
                            res_tag_next         = TAG_PW'(tag_rdata);
                            state_next           = S_DONE;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_DONE: begin
                // Hand the result over once the output register is free.
                if (out_take) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            issued_reg    <= '0;
            present_reg   <= '0;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            present_reg   <= present_next;
            row_valid_reg <= row_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        h_reg          <= h_next;
        w_reg          <= w_next;
        row_reg        <= row_next;
        last_reg       <= last_next;
        top_reg        <= top_next;
        col_reg        <= col_next;
        id_reg         <= id_next;
        tag_in_reg     <= tag_in_next;
        mask_reg       <= mask_next;
        ok_reg         <= ok_next;
        stamp_reg      <= stamp_next;
        runs_reg       <= runs_next;
        rv_reg         <= row_valid_reg[row_reg];
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_row_reg    <= res_row_next;
        res_col_reg    <= res_col_next;
        res_tag_reg    <= res_tag_next;
        if (state_reg == S_DONE && out_take) begin
            m_status_reg <= res_status_reg;
            m_id_reg     <= res_id_reg;
            m_row_reg    <= res_row_reg;
            m_col_reg    <= res_col_reg;
            m_tag_reg    <= res_tag_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_assigned_id  = m_id_reg;
    assign m_place_row    = m_row_reg;
    assign m_place_col    = m_col_reg;
    assign m_returned_tag = m_tag_reg;

`ifndef SYNTH
    a_issued_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        8'(issued_reg) <= MAX8)
        else $error("issued count above item limit");
    a_id_zero_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        !present_reg[0])
        else $error("id zero marked present");
    a_clear_all: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_operation == OP_CLEAR) |=> (issued_reg == '0 && present_reg == '0))
        else $error("clear left state behind");
    a_stamp_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EV && op_reg == OP_INSERT && stamp_reg)
            |-> (row_reg >= top_reg && row_reg <= last_reg))
        else $error("stamp row outside found rectangle");
`endif
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for grid_rectangle_first_fit_allocator: directed and random items
// checked against a behavioral model of the grid. Depends on gra_pkg and the RTL.
module tb
    import gra_pkg::*;
;

    localparam int ROWS = 8;
    localparam int COLS = 8;
    localparam int MAXID = 63;
    localparam int WATCH_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [OP_W-1:0] s_operation = OP_CLEAR;
    logic [DIM_W-1:0] s_rect_rows = '0;
    logic [DIM_W-1:0] s_rect_cols = '0;
    logic [POS_W-1:0] s_at_row = '0;
    logic [POS_W-1:0] s_at_col = '0;
    logic [ID_PW-1:0] s_item_id = '0;
    logic [TAG_PW-1:0] s_item_tag = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [ID_PW-1:0] m_assigned_id;
    logic [POS_W-1:0] m_place_row;
    logic [POS_W-1:0] m_place_col;
    logic [TAG_PW-1:0] m_returned_tag;

    typedef struct packed {
        status_t status;
        logic [ID_PW-1:0] id;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [TAG_PW-1:0] tag;
    } alloc_reply_t;

    // Model state of the grid
    logic [ID_PW-1:0] owner_grid [ROWS][COLS];
    logic [TAG_PW-1:0] tag_table [MAXID+1];
    bit live_ids [MAXID+1];
    int ids_issued;

    alloc_reply_t pending_replies [$];
    int errors = 0;
    int idle_cycles = 0;
    bit stim_done = 0;

    always #10 aclk = ~aclk;

    grid_rectangle_first_fit_allocator i_dut (.*);

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void wipe_grid();
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
                owner_grid[r][c] = '0;
        for (int i = 0; i <= MAXID; i++) begin
            tag_table[i] = '0;
            live_ids[i] = 0;
        end
        ids_issued = 0;
    endfunction

    function automatic bit area_free(int top, int left, int h, int w);
        if (h == 0 || w == 0 || top >= ROWS || left >= COLS) return 0;
        if (h > ROWS - top || w > COLS - left) return 0;
        for (int r = top; r < top + h; r++)
            for (int c = left; c < left + w; c++)
                if (owner_grid[r][c] != 0) return 0;
        return 1;
    endfunction

    // Compute the reply to one item and update the model grid
    function automatic alloc_reply_t place_or_free(op_t op, int h, int w, int ar, int ac,
                                                   int id, logic [TAG_PW-1:0] tg);
        alloc_reply_t rep;
        int nid;
        rep = '0;
        case (op)
            OP_INSERT: begin
                if (ids_issued >= MAXID) begin
                    rep.status = ST_EXHAUST;
                    return rep;
                end
                rep.status = ST_NO_SPACE;
                if (h == 0 || w == 0 || h > ROWS || w > COLS) return rep;
                for (int r = 0; r + h <= ROWS; r++)
                    for (int c = 0; c + w <= COLS; c++)
                        if (area_free(r, c, h, w)) begin
                            nid = ids_issued + 1;
                            for (int k = r; k < r + h; k++)
                                for (int l = c; l < c + w; l++)
                                    owner_grid[k][l] = ID_PW'(nid);
                            tag_table[nid] = tg;
                            live_ids[nid] = 1;
                            ids_issued = nid;
                            rep.status = ST_OK;
                            rep.id = ID_PW'(nid);
                            rep.row = POS_W'(r);
                            rep.col = POS_W'(c);
                            return rep;
                        end
            end
            OP_CHECK: begin
                rep.status = area_free(ar, ac, h, w) ? ST_OK : ST_NO_SPACE;
                rep.row = POS_W'(ar);
                rep.col = POS_W'(ac);
            end
            OP_REMOVE: begin
                if (id == 0 || id > MAXID || !live_ids[id]) begin
                    rep.status = ST_NO_ID;
                    return rep;
                end
                for (int r = 0; r < ROWS; r++)
                    for (int c = 0; c < COLS; c++)
                        if (owner_grid[r][c] == id) owner_grid[r][c] = '0;
                rep.tag = tag_table[id];
                tag_table[id] = '0;
                live_ids[id] = 0;
            end
            default: wipe_grid();
        endcase
        return rep;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Drive one item at the falling edge; hold until accepted. The falling edge
    // that drops valid is never the one that raises it for the next item.
    task automatic send_item(op_t op, int h, int w, int ar, int ac, int id, int tg);
        int g;
        g = gap_len();
        repeat (g + 1) @(negedge aclk);
        pending_replies.push_back(place_or_free(op, h, w, ar, ac, id, TAG_PW'(tg)));
        s_valid <= 1'b1;
        s_operation <= op;
        s_rect_rows <= DIM_W'(h);
        s_rect_cols <= DIM_W'(w);
        s_at_row <= POS_W'(ar);
        s_at_col <= POS_W'(ac);
        s_item_id <= ID_PW'(id);
        s_item_tag <= TAG_PW'(tg);
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_item(OP_INSERT, 8, 8, 0, 0, 0, 16'hFFFF);
        send_item(OP_INSERT, 1, 1, 7, 7, 63, 16'h0000);
        send_item(OP_CHECK, 1, 1, 7, 7, 0, 0);
        send_item(OP_REMOVE, 0, 0, 0, 0, 1, 0);
        send_item(OP_INSERT, 0, 3, 0, 0, 0, 5);
        send_item(OP_INSERT, 3, 0, 0, 0, 0, 5);
        send_item(OP_INSERT, 9, 1, 0, 0, 0, 5);
        send_item(OP_INSERT, 15, 15, 0, 0, 0, 5);
        send_item(OP_INSERT, 3, 5, 0, 0, 0, 16'hA5A5);
        send_item(OP_INSERT, 5, 3, 0, 0, 0, 16'h5A5A);
        send_item(OP_CHECK, 8, 8, 0, 0, 0, 0);
        send_item(OP_CHECK, 2, 2, 7, 7, 0, 0);
        send_item(OP_CHECK, 0, 1, 6, 6, 0, 0);
        send_item(OP_CHECK, 2, 3, 6, 5, 0, 0);
        send_item(OP_REMOVE, 0, 0, 0, 0, 0, 0);
        send_item(OP_REMOVE, 0, 0, 0, 0, 40, 0);
        send_item(OP_REMOVE, 0, 0, 0, 0, 3, 0);
        send_item(OP_REMOVE, 0, 0, 0, 0, 3, 0);
        send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    endtask

    // Fill the ID space with 1x1 items, then hit exhaustion
    task automatic test_exhaust();
        for (int i = 0; i < MAXID; i++) begin
            send_item(OP_INSERT, 1, 1, 0, 0, 0, $urandom_range(0, 65535));
            if ((i % 3) == 0) send_item(OP_REMOVE, 0, 0, 0, 0, i + 1, 0);
        end
        send_item(OP_INSERT, 1, 1, 0, 0, 0, 1);
        send_item(OP_INSERT, 15, 0, 0, 0, 0, 1);
        // hold the sender until the block has drained
        wait (pending_replies.size() == 0);
        send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random(int count);
        int p, h, w, id;
        op_t op;
        for (int n = 0; n < count; n++) begin
            p = $urandom_range(0, 99);
            if (p < 45) op = OP_INSERT;
            else if (p < 70) op = OP_CHECK;
            else if (p < 98) op = OP_REMOVE;
            else op = OP_CLEAR;
            // mostly small rectangles, a few out-of-range sizes
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
            if (op == OP_REMOVE && ids_issued > 0 && $urandom_range(0, 3) != 0)
                id = $urandom_range(1, ids_issued);
            else
                id = $urandom_range(0, 63);
            send_item(op, h, w, $urandom_range(0, 7), $urandom_range(0, 7), id,
                      $urandom_range(0, 65535));
        end
    endtask

    // Randomly stall the result side
    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if ($urandom_range(0, 99) < 8) m_ready <= 1'b0;
        else if ($urandom_range(0, 99) < 60) m_ready <= 1'b1;
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        alloc_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                report("unexpected result", int'(m_status), -1);
            end else begin
                want = pending_replies.pop_front();
                if (m_status !== want.status)
                    report("status", int'(m_status), int'(want.status));
                if (m_assigned_id !== want.id)
                    report("assigned_id", int'(m_assigned_id), int'(want.id));
                if (m_place_row !== want.row)
                    report("place_row", int'(m_place_row), int'(want.row));
                if (m_place_col !== want.col)
                    report("place_col", int'(m_place_col), int'(want.col));
                if (m_returned_tag !== want.tag)
                    report("returned_tag", int'(m_returned_tag), int'(want.tag));
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        wipe_grid();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_exhaust();
        test_random(1300);
        wait (pending_replies.size() == 0);
        repeat (100) @(posedge aclk);
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
